// ===== design/pdst_pkg.sv =====
// Shared types, constants and small lookup functions for the Pacific
// daylight-time detector. No dependencies.

package pdst_pkg;

   // Field and internal widths
   localparam int unsigned SECS_W  = 32;
   localparam int unsigned DAYS_W  = 16;
   localparam int unsigned SOD_W   = 17;
   localparam int unsigned DOE_W   = 18;
   localparam int unsigned YOE_W   = 9;
   localparam int unsigned DOY_W   = 9;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned WSUM_W  = 10;

   // Stages inside the date converter, and total latency of the top level
   localparam int unsigned CIVIL_STAGES = 8;
   localparam int unsigned RSP_LATENCY  = CIVIL_STAGES + 3;

   // Seconds to days: 86400 = 128 * 675, divide by 675 through a reciprocal
   localparam int unsigned SEC_SHIFT       = 7;
   localparam logic [25:0] DAY_RECIP       = 26'd50903317;
   localparam int unsigned DAY_RECIP_SHIFT = 35;
   localparam logic [9:0]  DAY_DIV         = 10'd675;

   // Second-of-day bounds of the switch hours (10:00 and 09:00 UTC)
   localparam logic [SOD_W-1:0] DST_START_SOD = 17'd36000;
   localparam logic [SOD_W-1:0] DST_END_SOD   = 17'd32400;

   // Day count to era and day of era
   localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
   localparam logic [19:0] ERA5_START  = 20'd730485;
   localparam logic [19:0] ERA4_START  = 20'd584388;

   localparam logic [DOE_W-1:0] CENT1    = 18'd36524;
   localparam logic [DOE_W-1:0] CENT2    = 18'd73048;
   localparam logic [DOE_W-1:0] CENT3    = 18'd109572;
   localparam logic [DOE_W-1:0] ERA_LAST = 18'd146096;

   // Reciprocals: quotient = (value * RECIP) >> SHIFT, exact over the used range
   localparam logic [16:0] QUAD_RECIP        = 17'd91930;   // (doe >> 2) / 365
   localparam int unsigned QUAD_RECIP_SHIFT  = 25;
   localparam logic [18:0] YEAR_RECIP        = 19'd367720;  // / 365
   localparam int unsigned YEAR_RECIP_SHIFT  = 27;
   localparam logic [11:0] MONTH_RECIP       = 12'd3427;    // / 153
   localparam int unsigned MONTH_RECIP_SHIFT = 19;
   localparam logic [10:0] WEEK_RECIP        = 11'd1171;    // / 7
   localparam int unsigned WEEK_RECIP_SHIFT  = 13;

   localparam logic [MONTH_W-1:0] MONTH_MARCH    = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_NOVEMBER = 4'd11;

   typedef struct packed {
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [3:0]         switch_day;
   } pdst_date_type;

   typedef struct packed {
      logic after_start;   // UTC hour is 10 or later
      logic before_end;    // UTC hour is below 9
   } pdst_hour_type;

   // Days from March 1 to the first of the month, month counted from March
   function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] mp);
      logic [DOY_W-1:0] d;
      case (mp)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Weekday offset table by civil month 1..12
   function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] month);
      logic [2:0] o;
      case (month)
         4'd1:    o = 3'd0;
         4'd2:    o = 3'd3;
         4'd3:    o = 3'd2;
         4'd4:    o = 3'd5;
         4'd5:    o = 3'd0;
         4'd6:    o = 3'd3;
         4'd7:    o = 3'd5;
         4'd8:    o = 3'd1;
         4'd9:    o = 3'd4;
         4'd10:   o = 3'd6;
         4'd11:   o = 3'd2;
         4'd12:   o = 3'd4;
         default: o = 3'd0;
      endcase
      return o;
   endfunction

endpackage

// ===== design/pdst_civil.sv =====
// Pipelined day-count to civil date converter, with the switch Sunday of
// the month. Depends on pdst_pkg.

module pdst_civil
   import pdst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [DAYS_W-1:0]   in_days,
   output logic                out_valid,
   output pdst_date_type       out_date
);

   logic [CIVIL_STAGES-1:0] valid_ff;

   // stage 1: era and day of era
   logic [19:0]       z_val;
   logic              era5_in;
   logic [19:0]       doe_full;
   logic [DOE_W-1:0]  c1_doe_ff;

   // stage 2: quadrennial and century counts
   logic [32:0]       quad_prod;
   logic [2:0]        cent_in;
   logic [DOE_W-1:0]  c2_doe_ff;
   logic [6:0]        c2_quad_ff;
   logic [2:0]        c2_cent_ff;
   logic              c2_last_ff;

   // stage 3: numerator of year of era
   logic [DOE_W-1:0]  num_in;
   logic [DOE_W-1:0]  c3_num_ff;
   logic [DOE_W-1:0]  c3_doe_ff;

   // stage 4: year of era
   logic [36:0]       year_prod;
   logic [YOE_W-1:0]  c4_yoe_ff;
   logic [DOE_W-1:0]  c4_doe_ff;

   // stage 5: day of year
   logic [1:0]        hund_in;
   logic [DOE_W-1:0]  yday_base;
   logic [DOE_W-1:0]  doy_full;
   logic [DOY_W-1:0]  c5_doy_ff;
   logic [YOE_W-1:0]  c5_yoe_ff;
   logic [1:0]        c5_hund_ff;

   // stage 6: month index and weekday sum
   logic [10:0]       mv;
   logic [22:0]       month_prod;
   logic [WSUM_W-1:0] wsum_in;
   logic [3:0]        c6_mp_ff;
   logic [DOY_W-1:0]  c6_doy_ff;
   logic [WSUM_W-1:0] c6_wsum_ff;

   // stage 7: month, day and full weekday sum
   logic [MONTH_W-1:0] month_in;
   logic [DOY_W-1:0]   day_full;
   logic [MONTH_W-1:0] c7_month_ff;
   logic [DAY_W-1:0]   c7_day_ff;
   logic [WSUM_W-1:0]  c7_wsum_ff;

   // stage 8: weekday of the first and switch day
   logic [20:0]        week_prod;
   logic [WSUM_W-1:0]  wrem;
   logic [3:0]         first_sun;
   pdst_date_type      date_in;
   pdst_date_type      c8_date_ff;

   always_comb begin
      z_val    = 20'(in_days) + EPOCH_SHIFT;
      era5_in  = (z_val >= ERA5_START);
      doe_full = z_val - (era5_in ? ERA5_START : ERA4_START);
   end

   always_comb begin
      quad_prod = 33'(c1_doe_ff[DOE_W-1:2]) * 33'(QUAD_RECIP);
      cent_in   = 3'(c1_doe_ff >= CENT1) + 3'(c1_doe_ff >= CENT2)
                + 3'(c1_doe_ff >= CENT3) + 3'(c1_doe_ff >= ERA_LAST);
   end

   assign num_in = c2_doe_ff - 18'(c2_quad_ff) + 18'(c2_cent_ff) - 18'(c2_last_ff);

   assign year_prod = 37'(c3_num_ff) * 37'(YEAR_RECIP);

   always_comb begin
      hund_in   = 2'(c4_yoe_ff >= 9'd100) + 2'(c4_yoe_ff >= 9'd200)
                + 2'(c4_yoe_ff >= 9'd300);
      yday_base = 18'(c4_yoe_ff) * 18'd365 + 18'(c4_yoe_ff[YOE_W-1:2]) - 18'(hund_in);
      doy_full  = c4_doe_ff - yday_base;
   end

   // year term of the weekday sum; the era adds 497 * era, a multiple of 7,
   // so only the year of era counts
   always_comb begin
      mv         = {c5_doy_ff, 2'b00} + 11'(c5_doy_ff) + 11'd2;
      month_prod = 23'(mv) * 23'(MONTH_RECIP);
      wsum_in    = 10'(c5_yoe_ff) + 10'(c5_yoe_ff[YOE_W-1:2]) - 10'(c5_hund_ff)
                 + 10'd1;
   end

   always_comb begin
      month_in = (c6_mp_ff < 4'd10) ? c6_mp_ff + 4'd3 : c6_mp_ff - 4'd9;
      day_full = c6_doy_ff - days_before_month(c6_mp_ff) + 9'd1;
   end

   always_comb begin
      week_prod  = 21'(c7_wsum_ff) * 21'(WEEK_RECIP);
      wrem       = c7_wsum_ff - 10'(week_prod[20:WEEK_RECIP_SHIFT]) * 10'd7;
      first_sun  = (wrem[2:0] == 3'd0) ? 4'd1 : 4'd8 - 4'(wrem[2:0]);
      date_in.month      = c7_month_ff;
      date_in.day        = c7_day_ff;
      date_in.switch_day = (c7_month_ff == MONTH_MARCH) ? first_sun + 4'd7 : first_sun;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[CIVIL_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      c1_doe_ff   <= doe_full[DOE_W-1:0];

      c2_doe_ff   <= c1_doe_ff;
      c2_quad_ff  <= quad_prod[QUAD_RECIP_SHIFT+6:QUAD_RECIP_SHIFT];
      c2_cent_ff  <= cent_in;
      c2_last_ff  <= (c1_doe_ff == ERA_LAST);

      c3_num_ff   <= num_in;
      c3_doe_ff   <= c2_doe_ff;

      c4_yoe_ff   <= year_prod[YEAR_RECIP_SHIFT+YOE_W-1:YEAR_RECIP_SHIFT];
      c4_doe_ff   <= c3_doe_ff;

      c5_doy_ff   <= doy_full[DOY_W-1:0];
      c5_yoe_ff   <= c4_yoe_ff;
      c5_hund_ff  <= hund_in;

      c6_mp_ff    <= month_prod[MONTH_RECIP_SHIFT+3:MONTH_RECIP_SHIFT];
      c6_doy_ff   <= c5_doy_ff;
      c6_wsum_ff  <= wsum_in;

      c7_month_ff <= month_in;
      c7_day_ff   <= day_full[DAY_W-1:0];
      c7_wsum_ff  <= c6_wsum_ff + 10'(month_offset(month_in));

      c8_date_ff  <= date_in;
   end

   assign out_valid = valid_ff[CIVIL_STAGES-1];
   assign out_date  = c8_date_ff;

endmodule

// ===== design/pacific_dst_from_unix_time_unit.sv =====
// Top level of the Pacific daylight-time detector: seconds split, date
// converter instance and final rule. Depends on pdst_pkg and pdst_civil.
//
// Usage:
//   Input channel: drive req_utc_seconds (Unix time, UTC seconds) and raise
//   start; the word is taken at every rising edge with start high and busy
//   low. busy stays low: the pipeline takes a new word in every cycle.
//   Result channel: rsp_strobe is high for exactly one cycle per word, with
//   rsp_daylight_time set when US Pacific daylight time is in force.
//   Results come out in the order the words went in.
//   Pipeline: 2 stages of seconds split, 8 in the date converter and 1 for
//   the rule lie between the accepting edge and the edge that takes the
//   result. Throughput: one word per cycle, set by the fully registered
//   pipeline; each stage holds at most one 32-bit-class multiply.
//   Reset (synchronous, active high) clears every valid bit; words in
//   flight are dropped and no strobe follows them.
//   The receiver cannot stall: every result is shown once and then gone.

module pacific_dst_from_unix_time_unit
   import pdst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [SECS_W-1:0] req_utc_seconds,
   output logic              rsp_strobe,
   output logic              rsp_daylight_time
);

   // stage 1: day estimate by reciprocal multiply
   logic [50:0]        day_prod;
   logic               s1_valid_ff;
   logic [SECS_W-1:0]  s1_secs_ff;
   logic [DAYS_W-1:0]  s1_days_ff;

   // stage 2: second of day and switch-hour flags
   logic [25:0]        day_rem;
   logic [SOD_W-1:0]   sod;
   logic               s2_valid_ff;
   logic [DAYS_W-1:0]  s2_days_ff;
   pdst_hour_type      s2_hour_ff;

   // hour flags ride alongside the date converter
   pdst_hour_type      hour_dly_ff [CIVIL_STAGES];

   logic               civil_valid;
   pdst_date_type      civil_date;
   pdst_hour_type      hour_at;
   logic               daylight_in;
   logic               rsp_strobe_ff;
   logic               rsp_daylight_ff;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // 86400 = 128 * 675: shift away the 128, then divide by 675 exactly
   assign day_prod = 51'(req_utc_seconds[SECS_W-1:SEC_SHIFT]) * 51'(DAY_RECIP);

   // remainder of the 675 divide, then glue the low seven bits back on
   always_comb begin
      day_rem = 26'(s1_secs_ff[SECS_W-1:SEC_SHIFT]) - 26'(s1_days_ff) * 26'(DAY_DIV);
      sod     = {day_rem[9:0], s1_secs_ff[SEC_SHIFT-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_secs_ff             <= req_utc_seconds;
      s1_days_ff             <= day_prod[DAY_RECIP_SHIFT+DAYS_W-1:DAY_RECIP_SHIFT];
      s2_days_ff             <= s1_days_ff;
      s2_hour_ff.after_start <= (sod >= DST_START_SOD);
      s2_hour_ff.before_end  <= (sod < DST_END_SOD);
   end

   // advance the hour flags in step with the converter stages
   always_ff @(posedge clock) begin
      hour_dly_ff[0] <= s2_hour_ff;
      for (int i = 1; i < CIVIL_STAGES; i++) begin
         hour_dly_ff[i] <= hour_dly_ff[i-1];
      end
   end

   pdst_civil u_civil (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_days   (s2_days_ff),
      .out_valid (civil_valid),
      .out_date  (civil_date)
   );

   assign hour_at = hour_dly_ff[CIVIL_STAGES-1];

   // Rule: winter months off, April..October on, March and November
   // decided against the switch Sunday and the UTC hour.
   always_comb begin
      if (civil_date.month < MONTH_MARCH || civil_date.month > MONTH_NOVEMBER) begin
         daylight_in = 1'b0;
      end else if (civil_date.month == MONTH_MARCH) begin
         if (civil_date.day < 5'(civil_date.switch_day)) begin
            daylight_in = 1'b0;
         end else if (civil_date.day > 5'(civil_date.switch_day)) begin
            daylight_in = 1'b1;
         end else begin
            daylight_in = hour_at.after_start;
         end
      end else if (civil_date.month == MONTH_NOVEMBER) begin
         if (civil_date.day < 5'(civil_date.switch_day)) begin
            daylight_in = 1'b1;
         end else if (civil_date.day > 5'(civil_date.switch_day)) begin
            daylight_in = 1'b0;
         end else begin
            daylight_in = hour_at.before_end;
         end
      end else begin
         daylight_in = 1'b1;
      end
   end

   // hold the result line low between strobes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff   <= 1'b0;
         rsp_daylight_ff <= 1'b0;
      end else begin
         rsp_strobe_ff   <= civil_valid;
         rsp_daylight_ff <= civil_valid & daylight_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_daylight_time = rsp_daylight_ff;

endmodule

// ===== design/pdst_checker.sv =====
// Port-level checker for the Pacific daylight-time detector and its bind
// to the top level. Depends on pdst_pkg.

module pdst_checker
   import pdst_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic              rsp_daylight_time
);

   // every accepted word yields a strobe after the fixed latency
   a_word_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_strobe)
      else $error("accepted word produced no result strobe");

   // no strobe without a word accepted at the matching edge
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, RSP_LATENCY))
      else $error("result strobe without an accepted word");

   // result line idles low between strobes
   a_quiet_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |-> !rsp_daylight_time)
      else $error("daylight flag high without a strobe");

endmodule

bind pacific_dst_from_unix_time_unit pdst_checker u_pdst_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for the Pacific daylight-time detector.
// Depends on pdst_pkg and pacific_dst_from_unix_time_unit.
`timescale 1ns / 100ps

module tb
   import pdst_pkg::*;
();

   // Switch hours in UTC: daylight time starts at 10:00 and ends at 09:00
   localparam int unsigned START_HOUR_UTC = 10;
   localparam int unsigned END_HOUR_UTC   = 9;
   localparam int unsigned MONTH_JAN      = 1;
   localparam int unsigned MONTH_FEB      = 2;
   localparam int unsigned MONTH_MAR      = 3;
   localparam int unsigned MONTH_APR      = 4;
   localparam int unsigned MONTH_JUL      = 7;
   localparam int unsigned MONTH_OCT      = 10;
   localparam int unsigned MONTH_NOV      = 11;
   localparam int unsigned MONTH_DEC      = 12;
   localparam int unsigned WORDS_PER_PHASE = 300;

   // Holds every predicted flag, oldest first, and matches results against it
   class dst_scoreboard;
      logic [SECS_W-1:0] secs_q[$];
      logic              flag_q[$];
      int unsigned       words_noted;
      int unsigned       results_seen;
      int unsigned       flags_set;
      int unsigned       mismatches;

      // Sakamoto month offsets, January first
      static const int unsigned weekday_shift[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

      // Work out the flag for one timestamp with plain 32-bit unsigned math
      static function logic dst_in_force(logic [31:0] secs);
         logic [31:0] day_count, hour, z, era, doe, yoe, doy, mp, dom, mon, yr;
         logic [31:0] wday, first_sunday, switch_day;
         day_count = secs / 32'd86400;
         hour      = (secs % 32'd86400) / 32'd3600;
         z    = day_count + 32'd719468;
         era  = z / 32'd146097;
         doe  = z - era * 32'd146097;
         yoe  = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
         doy  = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
         mp   = (32'd5 * doy + 32'd2) / 32'd153;
         dom  = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
         mon  = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
         yr   = yoe + era * 32'd400;
         if (mon <= 32'd2) begin
            yr = yr + 32'd1;
         end
         if (mon < MONTH_MAR || mon > MONTH_NOV) begin
            return 1'b0;
         end
         if (mon > MONTH_MAR && mon < MONTH_NOV) begin
            return 1'b1;
         end
         // March or November: no year borrow, weekday of the first of the month
         wday = (yr + yr / 32'd4 - yr / 32'd100 + yr / 32'd400
                 + weekday_shift[mon - 1] + 32'd1) % 32'd7;
         first_sunday = 32'd1 + (32'd7 - wday) % 32'd7;
         if (mon == MONTH_MAR) begin
            switch_day = first_sunday + 32'd7;
            if (dom != switch_day) begin
               return dom > switch_day;
            end
            return hour >= START_HOUR_UTC;
         end
         switch_day = first_sunday;
         if (dom != switch_day) begin
            return dom < switch_day;
         end
         return hour < END_HOUR_UTC;
      endfunction

      function void note_word(logic [SECS_W-1:0] secs);
         secs_q.push_back(secs);
         flag_q.push_back(dst_in_force(secs));
         words_noted++;
      endfunction

      function void check_result(logic got);
         logic [SECS_W-1:0] secs;
         logic              want;
         results_seen++;
         if (got === 1'b1) begin
            flags_set++;
         end
         if (flag_q.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected: expected none, actual %b",
                     $time, got);
            return;
         end
         secs = secs_q.pop_front();
         want = flag_q.pop_front();
         if (got !== want) begin
            mismatches++;
            $display("%0t: daylight_time for %0d: expected %b, actual %b",
                     $time, secs, want, got);
         end
      endfunction

      function int unsigned pending();
         return flag_q.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [SECS_W-1:0] req_utc_seconds;
   logic              rsp_strobe;
   logic              rsp_daylight_time;

   dst_scoreboard board;

   pacific_dst_from_unix_time_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_utc_seconds   (req_utc_seconds),
      .rsp_strobe        (rsp_strobe),
      .rsp_daylight_time (rsp_daylight_time)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Note each word at the edge that takes it; values read here are the
   // ones that stood before the edge, so driver updates cannot race them
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         board.note_word(req_utc_seconds);
      end
   end

   // Results cannot be held off: check every strobe at the edge ending it
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         board.check_result(rsp_daylight_time);
      end
   end

   // Unix seconds of a UTC civil date; wider than 32 bits so overflow is visible
   function automatic longint unsigned unix_at(int unsigned yr, int unsigned mon,
                                               int unsigned dom, int unsigned hr,
                                               int unsigned mi, int unsigned sc);
      longint unsigned y, era, yoe, doy, doe, days;
      y    = (mon <= MONTH_FEB) ? yr - 1 : yr;
      era  = y / 400;
      yoe  = y - era * 400;
      doy  = (153 * ((mon > MONTH_FEB) ? mon - 3 : mon + 9) + 2) / 5 + dom - 1;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468;
      return days * 86400 + hr * 3600 + mi * 60 + sc;
   endfunction

   // Draw one timestamp: mostly civil dates, often near the March and November
   // switch days and switch hours, the rest raw 32-bit noise
   function automatic logic [SECS_W-1:0] pick_seconds();
      int unsigned     yr, mon, dom, hr, mi, sc, pick;
      longint unsigned t;
      pick = $urandom_range(99);
      if (pick < 30) begin
         return $urandom();
      end
      yr  = $urandom_range(2105, 1970);
      mon = (pick < 75) ? (($urandom_range(1) == 0) ? MONTH_MAR : MONTH_NOV)
                        : $urandom_range(MONTH_DEC, MONTH_JAN);
      dom = (mon == MONTH_MAR || mon == MONTH_NOV) ? $urandom_range(15, 1)
                                                   : $urandom_range(28, 1);
      case ($urandom_range(3))
         0:       hr = END_HOUR_UTC - 1;
         1:       hr = END_HOUR_UTC;
         2:       hr = START_HOUR_UTC;
         default: hr = $urandom_range(23);
      endcase
      if ($urandom_range(3) == 0) begin
         mi = ($urandom_range(1) == 0) ? 0 : 59;
         sc = mi;
      end else begin
         mi = $urandom_range(59);
         sc = $urandom_range(59);
      end
      t = unix_at(yr, mon, dom, hr, mi, sc);
      return t[SECS_W-1:0];
   endfunction

   // Offer one word, idling first with the given odds; return once taken
   task automatic send_word(input logic [SECS_W-1:0] secs, input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_utc_seconds <= secs;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Drop start and hold off until every expected word has come back;
   // step one edge first so the last word is surely noted
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Run out of time: something hung
   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   initial begin
      logic [SECS_W-1:0] directed[$];
      int unsigned       idle_pct;

      board           = new();
      reset           = 1'b1;
      start           = 1'b0;
      req_utc_seconds = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words: range ends, top bit flips, each season and both
      // switch days around their switch hours, plus a non-leap century year
      directed.push_back(32'h0000_0000);
      directed.push_back(32'hFFFF_FFFF);
      directed.push_back(32'h7FFF_FFFF);
      directed.push_back(32'h8000_0000);
      directed.push_back(32'h5555_5555);
      directed.push_back(32'hAAAA_AAAA);
      directed.push_back(SECS_W'(unix_at(2000, MONTH_JAN, 15, 12, 0, 0)));
      directed.push_back(SECS_W'(unix_at(2000, MONTH_FEB, 29, 23, 59, 59)));
      directed.push_back(SECS_W'(unix_at(1999, MONTH_DEC, 31, 23, 59, 59)));
      directed.push_back(SECS_W'(unix_at(2010, MONTH_APR, 1, 0, 0, 0)));
      directed.push_back(SECS_W'(unix_at(2020, MONTH_JUL, 4, 12, 30, 0)));
      directed.push_back(SECS_W'(unix_at(2030, MONTH_OCT, 31, 23, 59, 59)));
      directed.push_back(SECS_W'(unix_at(2024, MONTH_MAR, 9, 23, 59, 59)));
      directed.push_back(SECS_W'(unix_at(2024, MONTH_MAR, 10, 9, 59, 59)));
      directed.push_back(SECS_W'(unix_at(2024, MONTH_MAR, 10, 10, 0, 0)));
      directed.push_back(SECS_W'(unix_at(2024, MONTH_MAR, 11, 0, 0, 0)));
      directed.push_back(SECS_W'(unix_at(2024, MONTH_NOV, 2, 12, 0, 0)));
      directed.push_back(SECS_W'(unix_at(2024, MONTH_NOV, 3, 8, 59, 59)));
      directed.push_back(SECS_W'(unix_at(2024, MONTH_NOV, 3, 9, 0, 0)));
      directed.push_back(SECS_W'(unix_at(2024, MONTH_NOV, 4, 0, 0, 0)));
      directed.push_back(SECS_W'(unix_at(2100, MONTH_MAR, 14, 10, 0, 0)));
      directed.push_back(SECS_W'(unix_at(2100, MONTH_NOV, 7, 8, 59, 59)));
      directed.push_back(SECS_W'(unix_at(1970, MONTH_MAR, 8, 10, 0, 0)));
      directed.push_back(SECS_W'(unix_at(2105, MONTH_NOV, 1, 9, 0, 0)));

      foreach (directed[i]) begin
         send_word(directed[i], 28);
      end

      // Three phases: light sender gaps, heavy gaps, then back to back.
      // Drain between phases so the pipeline runs empty at least once.
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 28 : (phase == 1) ? 76 : 0;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            send_word(pick_seconds(), idle_pct);
         end
         drain();
      end

      // Let any stray strobe surface before judging
      repeat (RSP_LATENCY + 4) @(posedge clock);

      if (board.pending() != 0) begin
         board.mismatches += board.pending();
         $display("%0t: %0d results never arrived: expected %0d more, actual 0",
                  $time, board.pending(), board.pending());
      end
      $display("summary: %0d timestamps sent, %0d results checked, %0d in daylight time",
               board.words_noted, board.results_seen, board.flags_set);
      $display("summary: %0d mismatches over light, heavy and no sender gaps",
               board.mismatches);
      if (board.mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
